@@ hw/rtl/gdd_pkg.sv @@
// ----------------------------------------------------------------------------
// Graph degree and diameter: shared definitions
// Default sizes, saturation limits and the item mode codes.
// ----------------------------------------------------------------------------
package gdd_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int WORD_BITS_DEF    = 64;

    localparam logic [15:0] DEG_SAT  = 16'hFFFF;
    localparam logic [19:0] EDGE_SAT = 20'hF_FFFF;
    localparam logic [23:0] SUM_SAT  = 24'hFF_FFFF;
    localparam logic [7:0]  DIAM_SAT = 8'hFF;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REPORT = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

endpackage

@@ hw/rtl/graph_degree_and_diameter_core.sv @@
// ----------------------------------------------------------------------------
// Graph degree and diameter core
// Stores an undirected graph and reports degree statistics and diameter.
// ----------------------------------------------------------------------------
// Input beats carry a mode with two vertices. An add beat stores the edge by
// reading and writing back the adjacency word and degree of the first
// endpoint, then of the second. A clear beat, and reset itself, sweep the
// adjacency memory one word per cycle (MAX_VERTICES * row words, 1024 words
// by default) while no beat is accepted; configuration writes are taken at
// any time. A report beat scans the degree memory over the n vertices, then
// runs a breadth-first search from each of the n vertices. Each search resets
// the distance memory, seeds the queue with the source, and for every vertex
// reached reads it from the queue, reads its distance and scans its adjacency
// row, until the queue is found empty; these steps run one after another,
// set by the single read port of the adjacency and distance memories.
// The mean is formed by a bit-serial divider that runs alongside the search
// and holds back the result when the search is shorter.
// The result beat is held in an output register until the receiver takes it;
// a stalled receiver delays only the completion of the next report.
// Add and clear beats produce no result beat.
// ----------------------------------------------------------------------------
module graph_degree_and_diameter_core #(
    parameter int MAX_VERTICES = gdd_pkg::MAX_VERTICES_DEF,
    parameter int WORD_BITS    = gdd_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_vertex_u,
    input  logic [7:0]  i_vertex_v,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [19:0] o_edge_total,
    output logic [15:0] o_min_degree,
    output logic [15:0] o_max_degree,
    output logic [23:0] o_degree_sum,
    output logic [19:0] o_mean_degree_tenths,
    output logic [7:0]  o_diameter
);

    localparam int ROW_WORDS = (MAX_VERTICES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADJ_DEPTH = MAX_VERTICES * ROW_WORDS;
    localparam int AW        = $clog2(ADJ_DEPTH);
    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
    localparam int CLR_W     = $clog2(ADJ_DEPTH + 1);
    localparam int DIST_W    = VW + 1;
    localparam int SUM_W     = 16 + VW;
    localparam int NUM_W     = SUM_W + 6;
    localparam int DEN_W     = CNT_W + 1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD_U, S_WR_U, S_RD_V, S_WR_V,
        S_STAT, S_STAT_END, S_DIV_GO, S_INIT, S_SEED,
        S_DEQ, S_DEQ2, S_DEQ3, S_SCAN, S_SCAN_END, S_DONE
    } t_state;

    t_state             r_state;
    logic [8:0]         r_cfg;
    logic [CLR_W-1:0]   r_idx;
    logic [VW-1:0]      r_u;
    logic [VW-1:0]      r_v;
    logic [VW-1:0]      r_src;
    logic [VW-1:0]      r_cur;
    logic [DIST_W-1:0]  r_du;
    logic [DIST_W-1:0]  r_diam;
    logic [CNT_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_tail;
    logic [19:0]        r_edges;
    logic [15:0]        r_min;
    logic [15:0]        r_max;
    logic [SUM_W-1:0]   r_sum;
    logic               r_pv;
    logic               r_sv;
    logic [VW-1:0]      r_scol;
    logic               r_o_valid;
    logic [19:0]        r_o_edges;
    logic [15:0]        r_o_min;
    logic [15:0]        r_o_max;
    logic [23:0]        r_o_sum;
    logic [19:0]        r_o_mean;
    logic [7:0]         r_o_diam;

    logic [CNT_W-1:0]   w_n;
    logic [CNT_W-1:0]   w_nm1;
    logic               w_accept;
    logic               w_out_load;

    logic               adj_we;
    logic [AW-1:0]      adj_waddr;
    logic [AW-1:0]      adj_raddr;
    logic [WORD_BITS-1:0] adj_wdata;
    logic [WORD_BITS-1:0] adj_rdata;
    logic               deg_we;
    logic [VW-1:0]      deg_waddr;
    logic [VW-1:0]      deg_raddr;
    logic [15:0]        deg_wdata;
    logic [15:0]        deg_rdata;
    logic [15:0]        deg_inc;
    logic               dist_we;
    logic [VW-1:0]      dist_waddr;
    logic [VW-1:0]      dist_raddr;
    logic [DIST_W-1:0]  dist_wdata;
    logic [DIST_W-1:0]  dist_rdata;
    logic               q_we;
    logic [VW-1:0]      q_waddr;
    logic [VW-1:0]      q_raddr;
    logic [VW-1:0]      q_wdata;
    logic [VW-1:0]      q_rdata;
    logic               w_found;
    logic               div_start;
    logic               div_busy;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [NUM_W-1:0]   div_quot;

    function automatic logic [AW-1:0] adj_addr(input logic [VW-1:0] row,
                                               input logic [VW-1:0] col);
        logic [AW-1:0] base;
        base     = AW'(AW'(row) * AW'(ROW_WORDS));
        adj_addr = AW'(base + AW'(col / WORD_BITS));
    endfunction

    function automatic logic [WORD_BITS-1:0] col_bit(input logic [VW-1:0] col);
        col_bit = WORD_BITS'(1) << (col % WORD_BITS);
    endfunction

    always_comb begin
        if (r_cfg == 9'd0) begin
            w_n = CNT_W'(1);
        end else if (16'(r_cfg) > 16'(MAX_VERTICES)) begin
            w_n = CNT_W'(MAX_VERTICES);
        end else begin
            w_n = CNT_W'(r_cfg);
        end
        w_nm1 = w_n - CNT_W'(1);
    end

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign deg_inc  = (deg_rdata == gdd_pkg::DEG_SAT) ? deg_rdata : deg_rdata + 16'd1;
    assign w_found  = r_sv && (dist_rdata == '1) && ((adj_rdata & col_bit(r_scol)) != '0);
    assign div_start = (r_state == S_DIV_GO);
    assign div_num   = NUM_W'(NUM_W'(r_sum) * NUM_W'(20) + NUM_W'(w_n));
    assign div_den   = DEN_W'({w_n, 1'b0});
    assign w_out_load = (r_state == S_DONE) && (!r_o_valid || i_ready) && !div_busy;

    always_comb begin
        adj_we     = 1'b0;
        adj_waddr  = adj_addr(r_u, r_v);
        adj_wdata  = adj_rdata | col_bit(r_v);
        adj_raddr  = adj_addr(r_u, r_v);
        deg_we     = 1'b0;
        deg_waddr  = r_u;
        deg_wdata  = deg_inc;
        deg_raddr  = r_u;
        dist_we    = 1'b0;
        dist_waddr = r_scol;
        dist_wdata = r_du + DIST_W'(1);
        dist_raddr = r_idx[VW-1:0];
        q_we       = 1'b0;
        q_waddr    = r_tail[VW-1:0];
        q_wdata    = r_scol;
        q_raddr    = r_head[VW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_idx[AW-1:0];
                adj_wdata = '0;
                deg_we    = r_idx < CLR_W'(MAX_VERTICES);
                deg_waddr = r_idx[VW-1:0];
                deg_wdata = '0;
            end
            S_WR_U: begin
                adj_we = 1'b1;
                deg_we = 1'b1;
            end
            S_RD_V: begin
                adj_raddr = adj_addr(r_v, r_u);
                deg_raddr = r_v;
            end
            S_WR_V: begin
                adj_we    = 1'b1;
                adj_waddr = adj_addr(r_v, r_u);
                adj_wdata = adj_rdata | col_bit(r_u);
                deg_we    = 1'b1;
                deg_waddr = r_v;
            end
            S_STAT: begin
                deg_raddr = r_idx[VW-1:0];
            end
            S_INIT: begin
                dist_we    = 1'b1;
                dist_waddr = r_idx[VW-1:0];
                dist_wdata = '1;
            end
            S_SEED: begin
                dist_we    = 1'b1;
                dist_waddr = r_src;
                dist_wdata = '0;
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = r_src;
            end
            S_DEQ2: begin
                dist_raddr = q_rdata;
            end
            S_SCAN, S_SCAN_END: begin
                adj_raddr = adj_addr(r_cur, r_idx[VW-1:0]);
                dist_we   = w_found;
                q_we      = w_found;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cfg     <= 9'd256;
            r_idx     <= '0;
            r_edges   <= '0;
            r_diam    <= '0;
            r_pv      <= 1'b0;
            r_sv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            r_pv   <= (r_state == S_STAT);
            r_sv   <= (r_state == S_SCAN);
            r_scol <= r_idx[VW-1:0];
            if (r_pv) begin
                if (deg_rdata < r_min) begin
                    r_min <= deg_rdata;
                end
                if (deg_rdata > r_max) begin
                    r_max <= deg_rdata;
                end
                r_sum <= r_sum + SUM_W'(deg_rdata);
            end
            if (w_found) begin
                if (r_tail < CNT_W'(MAX_VERTICES)) begin
                    r_tail <= r_tail + CNT_W'(1);
                end
                if (r_du + DIST_W'(1) > r_diam) begin
                    r_diam <= r_du + DIST_W'(1);
                end
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_edges <= '0;
                    r_diam  <= '0;
                    r_idx   <= r_idx + CLR_W'(1);
                    if (r_idx == CLR_W'(ADJ_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx <= '0;
                        unique case (gdd_pkg::t_mode'(i_mode))
                            gdd_pkg::MODE_ADD: begin
                                r_u <= VW'(i_vertex_u);
                                r_v <= VW'(i_vertex_v);
                                if (16'(i_vertex_u) < 16'(w_n) &&
                                    16'(i_vertex_v) < 16'(w_n)) begin
                                    r_state <= S_RD_U;
                                end
                            end
                            gdd_pkg::MODE_REPORT: begin
                                r_min   <= gdd_pkg::DEG_SAT;
                                r_max   <= '0;
                                r_sum   <= '0;
                                r_diam  <= '0;
                                r_src   <= '0;
                                r_state <= S_STAT;
                            end
                            gdd_pkg::MODE_CLEAR: begin
                                r_state <= S_CLEAR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD_U: r_state <= S_WR_U;
                S_WR_U: r_state <= S_RD_V;
                S_RD_V: r_state <= S_WR_V;
                S_WR_V: begin
                    if (r_edges != gdd_pkg::EDGE_SAT) begin
                        r_edges <= r_edges + 20'd1;
                    end
                    r_state <= S_IDLE;
                end
                S_STAT: begin
                    r_idx <= r_idx + CLR_W'(1);
                    if (r_idx == CLR_W'(w_nm1)) begin
                        r_state <= S_STAT_END;
                    end
                end
                S_STAT_END: r_state <= S_DIV_GO;
                S_DIV_GO: begin
                    r_idx   <= '0;
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_idx <= r_idx + CLR_W'(1);
                    if (r_idx == CLR_W'(w_nm1)) begin
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    r_head  <= '0;
                    r_tail  <= CNT_W'(1);
                    r_state <= S_DEQ;
                end
                S_DEQ: begin
                    r_idx <= '0;
                    if (r_head == r_tail) begin
                        if (r_src == w_nm1[VW-1:0]) begin
                            r_state <= S_DONE;
                        end else begin
                            r_src   <= r_src + VW'(1);
                            r_state <= S_INIT;
                        end
                    end else begin
                        r_head  <= r_head + CNT_W'(1);
                        r_state <= S_DEQ2;
                    end
                end
                S_DEQ2: begin
                    r_cur   <= q_rdata;
                    r_state <= S_DEQ3;
                end
                S_DEQ3: begin
                    r_du    <= dist_rdata;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_idx <= r_idx + CLR_W'(1);
                    if (r_idx == CLR_W'(w_nm1)) begin
                        r_state <= S_SCAN_END;
                    end
                end
                S_SCAN_END: r_state <= S_DEQ;
                S_DONE: begin
                    if (w_out_load) begin
                        r_o_edges <= r_edges;
                        r_o_min   <= r_min;
                        r_o_max   <= r_max;
                        r_o_sum   <= (32'(r_sum) > 32'(gdd_pkg::SUM_SAT)) ?
                                     gdd_pkg::SUM_SAT : 24'(r_sum);
                        r_o_mean  <= 20'(div_quot);
                        r_o_diam  <= (32'(r_diam) > 32'(gdd_pkg::DIAM_SAT)) ?
                                     gdd_pkg::DIAM_SAT : 8'(r_diam);
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid              = r_o_valid;
    assign o_edge_total         = r_o_edges;
    assign o_min_degree         = r_o_min;
    assign o_max_degree         = r_o_max;
    assign o_degree_sum         = r_o_sum;
    assign o_mean_degree_tenths = r_o_mean;
    assign o_diameter           = r_o_diam;

    gdd_ram #(.DEPTH(ADJ_DEPTH), .WIDTH(WORD_BITS)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );

    gdd_ram #(.DEPTH(MAX_VERTICES), .WIDTH(16)) u_deg (
        .i_clk(i_clk), .i_we(deg_we), .i_waddr(deg_waddr), .i_wdata(deg_wdata),
        .i_raddr(deg_raddr), .o_rdata(deg_rdata)
    );

    gdd_ram #(.DEPTH(MAX_VERTICES), .WIDTH(DIST_W)) u_dist (
        .i_clk(i_clk), .i_we(dist_we), .i_waddr(dist_waddr), .i_wdata(dist_wdata),
        .i_raddr(dist_raddr), .o_rdata(dist_rdata)
    );

    gdd_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    gdd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_busy(div_busy), .o_quot(div_quot)
    );

endmodule

@@ hw/rtl/gdd_ram.sv @@
// ----------------------------------------------------------------------------
// Graph degree and diameter: simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdd_ram #(
    parameter int DEPTH = gdd_pkg::MAX_VERTICES_DEF,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/gdd_div.sv @@
// ----------------------------------------------------------------------------
// Graph degree and diameter: restoring divider
// Produces one quotient bit per cycle and holds the quotient until restarted.
// ----------------------------------------------------------------------------
module gdd_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   n_shift;
    logic             n_take;

    always_comb begin
        n_shift = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        n_take  = n_shift >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NUM_W);
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= n_take ? n_shift - {1'b0, r_den} : n_shift;
            r_quot <= {r_quot[NUM_W-2:0], n_take};
            r_cnt  <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule
